### sv/tlvd_pkg.sv
// ----------------------------------------------------------------------------
// tlvd_pkg: shared types, codes and helpers of the TLV frame deframer
// Holds the register map, the parser phase type, the result record and the
// metadata decode used when a frame ends.
// ----------------------------------------------------------------------------
package tlvd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 96;
  localparam int unsigned OUT_TUSER_W = 4;

  // Register map.
  localparam logic [CFG_IDX_W-1:0] REG_RX_PACKET_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TX_RESULT_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_FRAME_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIO_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TX_OK_CODE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TX_BUSY_CODE    = 3'd6;

  // Register reset values.
  localparam logic [7:0]  RST_RX_PACKET_CODE   = 8'd2;
  localparam logic [7:0]  RST_TX_RESULT_CODE   = 8'd3;
  localparam logic [7:0]  RST_ERROR_FRAME_CODE = 8'd4;
  localparam logic [15:0] RST_MAX_PAYLOAD_LEN  = 16'd260;
  localparam logic [15:0] RST_MAX_RADIO_LEN    = 16'd256;
  localparam logic [7:0]  RST_TX_OK_CODE       = 8'd0;
  localparam logic [7:0]  RST_TX_BUSY_CODE     = 8'd1;

  // Frame type codes.
  localparam logic [1:0] FT_RX    = 2'd0;
  localparam logic [1:0] FT_TX    = 2'd1;
  localparam logic [1:0] FT_ERR   = 2'd2;
  localparam logic [1:0] FT_FAULT = 2'd3;

  // Transmit outcome codes.
  localparam logic [1:0] OC_SUCCESS   = 2'd0;
  localparam logic [1:0] OC_BUSY      = 2'd1;
  localparam logic [1:0] OC_RADIO_ERR = 2'd2;

  // Input kinds.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  localparam logic [15:0] META_LEN = 16'd4;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [7:0]  rx_packet_code;
    logic [7:0]  tx_result_code;
    logic [7:0]  error_frame_code;
    logic [15:0] max_payload_len;
    logic [15:0] max_radio_len;
    logic [7:0]  tx_ok_code;
    logic [7:0]  tx_busy_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         frame_type;
    logic               has_byte;
    logic [7:0]         payload_byte;
    logic [15:0]        byte_index;
    logic               last;
    logic               meta_valid;
    logic signed [15:0] rssi_level;
    logic signed [15:0] snr_cdb;
    logic [7:0]         tx_status;
    logic [7:0]         tx_flags;
    logic [15:0]        tx_seq;
    logic [1:0]         tx_outcome;
  } result_t;

  // Marks a result as the end of a frame and adds the decoded metadata when
  // the frame length passes its check.
  function automatic result_t fill_meta(input result_t res, input logic [1:0] kind,
                                        input logic [15:0] len, input logic [15:0] word_a,
                                        input logic [15:0] word_b, input cfg_t cfg);
    result_t r;
    r = res;
    r.last = 1'b1;
    if (kind == FT_RX) begin
      if (len >= META_LEN && (len - META_LEN) <= cfg.max_radio_len) begin
        r.meta_valid = 1'b1;
        r.rssi_level = $signed(word_a);
        r.snr_cdb    = $signed(word_b);
      end
    end else if (kind == FT_TX) begin
      if (len == META_LEN) begin
        r.meta_valid = 1'b1;
        r.tx_status  = word_a[7:0];
        r.tx_flags   = word_a[15:8];
        r.tx_seq     = word_b;
        if (word_a[7:0] == cfg.tx_ok_code) begin
          r.tx_outcome = OC_SUCCESS;
        end else if (word_a[7:0] == cfg.tx_busy_code) begin
          r.tx_outcome = OC_BUSY;
        end else begin
          r.tx_outcome = OC_RADIO_ERR;
        end
      end
    end
    return r;
  endfunction

endpackage

### sv/tlvd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tlvd_cfg_regs: configuration register file
// Seven registers written through an index/data port, reset to their
// default codes and limits.
// ----------------------------------------------------------------------------
module tlvd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tlvd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tlvd_pkg::CFG_DATA_W-1:0] wr_data,
  output tlvd_pkg::cfg_t                 cfg
);
  import tlvd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rx_packet_code   <= RST_RX_PACKET_CODE;
      cfg_r.tx_result_code   <= RST_TX_RESULT_CODE;
      cfg_r.error_frame_code <= RST_ERROR_FRAME_CODE;
      cfg_r.max_payload_len  <= RST_MAX_PAYLOAD_LEN;
      cfg_r.max_radio_len    <= RST_MAX_RADIO_LEN;
      cfg_r.tx_ok_code       <= RST_TX_OK_CODE;
      cfg_r.tx_busy_code     <= RST_TX_BUSY_CODE;
    end else if (wr_en) begin
      case (wr_index)
        REG_RX_PACKET_CODE:   cfg_r.rx_packet_code   <= wr_data[7:0];
        REG_TX_RESULT_CODE:   cfg_r.tx_result_code   <= wr_data[7:0];
        REG_ERROR_FRAME_CODE: cfg_r.error_frame_code <= wr_data[7:0];
        REG_MAX_PAYLOAD_LEN:  cfg_r.max_payload_len  <= wr_data;
        REG_MAX_RADIO_LEN:    cfg_r.max_radio_len    <= wr_data;
        REG_TX_OK_CODE:       cfg_r.tx_ok_code       <= wr_data[7:0];
        REG_TX_BUSY_CODE:     cfg_r.tx_busy_code     <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/tlvd_parser.sv
// ----------------------------------------------------------------------------
// tlvd_parser: frame header and payload parser
// Tracks the header phase, checks type and length, counts payload bytes and
// captures the four metadata bytes. Produces at most one result per item.
// ----------------------------------------------------------------------------
module tlvd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              kind,
  input  logic [7:0]        data_byte,
  input  tlvd_pkg::cfg_t    cfg,
  output logic              res_valid,
  output tlvd_pkg::result_t res
);
  import tlvd_pkg::*;

  phase_t      phase_r,  phase_nxt;
  logic        halted_r, halted_nxt;
  logic [1:0]  kind_r,   kind_nxt;
  logic [15:0] len_r,    len_nxt;
  logic [15:0] seen_r,   seen_nxt;
  logic [15:0] meta_a_r, meta_a_nxt;
  logic [15:0] meta_b_r, meta_b_nxt;
  logic [7:0]  hdr_r,    hdr_nxt;

  logic        data_go;
  logic [1:0]  hdr_kind;
  logic [15:0] len_full;
  logic        hdr_fault;
  logic        is_last;

  assign data_go  = accept && (kind == KIND_DATA) && !halted_r;
  assign len_full = {data_byte, len_r[7:0]};

  // Receive code has priority over transmit, transmit over error.
  always_comb begin
    if (hdr_r == cfg.rx_packet_code) begin
      hdr_kind = FT_RX;
    end else if (hdr_r == cfg.tx_result_code) begin
      hdr_kind = FT_TX;
    end else if (hdr_r == cfg.error_frame_code) begin
      hdr_kind = FT_ERR;
    end else begin
      hdr_kind = FT_FAULT;
    end
  end

  assign hdr_fault = (hdr_kind == FT_FAULT) || (len_full > cfg.max_payload_len);
  assign is_last   = ({1'b0, seen_r} + 17'd1) >= {1'b0, len_r};

  // Next state.
  always_comb begin
    phase_nxt  = phase_r;
    halted_nxt = halted_r;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    meta_a_nxt = meta_a_r;
    meta_b_nxt = meta_b_r;
    hdr_nxt    = hdr_r;
    if (accept && kind == KIND_RESET) begin
      phase_nxt  = PH_TYPE;
      halted_nxt = 1'b0;
      kind_nxt   = FT_RX;
      len_nxt    = '0;
      seen_nxt   = '0;
      meta_a_nxt = '0;
      meta_b_nxt = '0;
      hdr_nxt    = '0;
    end else if (data_go) begin
      case (phase_r)
        PH_TYPE: begin
          hdr_nxt   = data_byte;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {8'h00, data_byte};
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt  = len_full;
          kind_nxt = hdr_kind;
          if (hdr_fault) begin
            halted_nxt = 1'b1;
          end else begin
            seen_nxt   = '0;
            meta_a_nxt = '0;
            meta_b_nxt = '0;
            phase_nxt  = (len_full == 16'd0) ? PH_TYPE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          case (seen_r)
            16'd0:   meta_a_nxt = {meta_a_r[15:8], data_byte};
            16'd1:   meta_a_nxt = {data_byte, meta_a_r[7:0]};
            16'd2:   meta_b_nxt = {meta_b_r[15:8], data_byte};
            16'd3:   meta_b_nxt = {data_byte, meta_b_r[7:0]};
            default: ;
          endcase
          if (is_last) begin
            phase_nxt = PH_TYPE;
          end else begin
            seen_nxt = seen_r + 16'd1;
          end
        end
        default: phase_nxt = PH_TYPE;
      endcase
    end
  end

  // Result.
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (data_go) begin
      case (phase_r)
        PH_LEN_HI: begin
          if (hdr_fault) begin
            res_valid      = 1'b1;
            res.frame_type = FT_FAULT;
            res.last       = 1'b1;
          end else if (len_full == 16'd0) begin
            // An empty frame ends right at its header.
            res_valid      = 1'b1;
            res.frame_type = hdr_kind;
            res            = fill_meta(res, hdr_kind, 16'd0, 16'd0, 16'd0, cfg);
          end
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.frame_type   = kind_r;
          res.has_byte     = 1'b1;
          res.payload_byte = data_byte;
          res.byte_index   = seen_r;
          if (is_last) begin
            res = fill_meta(res, kind_r, len_r, meta_a_nxt, meta_b_nxt, cfg);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      halted_r <= 1'b0;
      kind_r   <= FT_RX;
      len_r    <= '0;
      seen_r   <= '0;
      meta_a_r <= '0;
      meta_b_r <= '0;
      hdr_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      halted_r <= halted_nxt;
      kind_r   <= kind_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
      meta_a_r <= meta_a_nxt;
      meta_b_r <= meta_b_nxt;
      hdr_r    <= hdr_nxt;
    end
  end

endmodule

### sv/tlvd_out_skid.sv
// ----------------------------------------------------------------------------
// tlvd_out_skid: result register with skid stage
// Holds results for the output channel; the skid entry absorbs one result
// while the output is stalled, so ready upstream comes straight from a flop.
// ----------------------------------------------------------------------------
module tlvd_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tlvd_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output tlvd_pkg::result_t out_data
);
  import tlvd_pkg::*;

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  logic    pop;

  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/tlv_frame_deframer_decoder_core.sv
// ----------------------------------------------------------------------------
// tlv_frame_deframer_decoder_core: TLV link deframer and metadata decoder
// Each result is registered in the output stage, or in the skid entry while the output is stalled.
// Throughput: one item per cycle while in_tready is high; the parser state update is a single pass.
// A stalled output is absorbed by one skid entry; in_tready drops only then.
// Synchronous active-low reset clears the parser, the result stages and the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
module tlv_frame_deframer_decoder_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input item.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tlvd_pkg::IN_TDATA_W-1:0]  in_tdata,  // [7:0] data_byte
  input  logic                             in_tuser,  // [0] kind
  // Result item.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] payload_byte, [23:8] byte_index, [39:24] rssi_level, [55:40] snr_cdb,
  // [63:56] tx_status, [71:64] tx_flags, [87:72] tx_seq, [89:88] tx_outcome,
  // [95:90] zero
  output logic [tlvd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] frame_type, [2] has_byte, [3] meta_valid
  output logic [tlvd_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                             out_tlast,  // last
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tlvd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlvd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tlvd_pkg::*;

  cfg_t    cfg;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  logic    can_push;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_tready = can_push;
  assign in_accept = in_tvalid && in_tready;

  tlvd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tlvd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .kind      (in_tuser),
    .data_byte (in_tdata[7:0]),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  tlvd_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {6'b0, out_res.tx_outcome, out_res.tx_seq, out_res.tx_flags,
                      out_res.tx_status, out_res.snr_cdb, out_res.rssi_level,
                      out_res.byte_index, out_res.payload_byte};
  assign out_tuser = {out_res.meta_valid, out_res.has_byte, out_res.frame_type};
  assign out_tlast = out_res.last;

endmodule

### sv/tlvd_checker.sv
// ----------------------------------------------------------------------------
// tlvd_checker: port-level checks of the TLV deframer
// Watches the top-level ports and flags results that break the framing rules.
// ----------------------------------------------------------------------------
module tlvd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tlvd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [tlvd_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                             out_tlast
);
  import tlvd_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Input back-pressure only happens with a result waiting.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // A header fault is always the end of the frame.
  a_fault_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == FT_FAULT |-> out_tlast && out_tuser[2] == 1'b0)
    else $error("header fault not marked last");

  // Results without a byte, and decoded metadata, appear only on the last one.
  a_meta_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[3] || !out_tuser[2]) |-> out_tlast)
    else $error("metadata or empty result on a non-final result");

endmodule

bind tlv_frame_deframer_decoder_core tlvd_checker u_tlvd_checker (.*);
